>>> src/gme_pkg.sv
package gme_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN,
    ST_WB,
    ST_OUT
  } gme_state_t;

  localparam logic [2:0] MOVE_UP    = 3'd0;
  localparam logic [2:0] MOVE_DOWN  = 3'd1;
  localparam logic [2:0] MOVE_LEFT  = 3'd2;
  localparam logic [2:0] MOVE_RIGHT = 3'd3;
  localparam logic [2:0] MOVE_NONE  = 3'd4;

  // scan slot after the four neighbors: read of the current cell
  localparam logic [2:0] SLOT_HERE = 3'd4;

  localparam int CELL_OBSTACLE  = 1;
  localparam int CELL_DEAD_END  = 2;
  localparam int DEAD_END_SIDES = 3;

  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;
  localparam int POS_W  = 4;

  localparam logic [1:0] REG_START_ROW = 2'd0;
  localparam logic [1:0] REG_START_COL = 2'd1;
  localparam logic [1:0] REG_DEST_ROW  = 2'd2;
  localparam logic [1:0] REG_DEST_COL  = 2'd3;

  typedef struct packed {
    logic [POS_W-1:0] start_row;
    logic [POS_W-1:0] start_col;
    logic [POS_W-1:0] dest_row;
    logic [POS_W-1:0] dest_col;
  } gme_cfg_t;

  typedef struct packed {
    logic capture;
    logic load_start;
    logic res_arrived;
    logic res_idle;
    logic clr_step;
    logic scan_step;
    logic wb;
    logic out_load;
  } gme_cmd_t;

  typedef struct packed {
    logic arrived;
    logic in_grid;
    logic clr_last;
    logic scan_last;
    logic out_busy;
  } gme_sts_t;

endpackage

>>> src/gme_in_if.sv
interface gme_in_if;
  logic valid;
  logic ready;
  logic operation;
  logic obstacle_up;
  logic obstacle_down;
  logic obstacle_left;
  logic obstacle_right;

  modport source (
    output valid, operation, obstacle_up, obstacle_down, obstacle_left, obstacle_right,
    input  ready
  );

  modport sink (
    input  valid, operation, obstacle_up, obstacle_down, obstacle_left, obstacle_right,
    output ready
  );
endinterface

>>> src/gme_out_if.sv
interface gme_out_if;
  logic       valid;
  logic       ready;
  logic       arrived;
  logic [2:0] move;
  logic [3:0] new_row;
  logic [3:0] new_col;

  modport source (
    output valid, arrived, move, new_row, new_col,
    input  ready
  );

  modport sink (
    input  valid, arrived, move, new_row, new_col,
    output ready
  );
endinterface

>>> src/gme_ram.sv
module gme_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> src/gme_ctrl.sv
module gme_ctrl
  import gme_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_operation,
  output logic     in_ready,
  output gme_cmd_t cmd,
  input  gme_sts_t sts
);

  gme_state_t state_r, state_nxt;
  logic       reply_r, reply_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      reply_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      reply_r <= reply_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    reply_nxt = reply_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          priority if (in_operation) begin
            cmd.load_start = 1'b1;
            cmd.res_idle   = 1'b1;
            reply_nxt      = 1'b1;
            state_nxt      = ST_CLEAR;
          end else if (sts.arrived) begin
            cmd.res_arrived = 1'b1;
            state_nxt       = ST_OUT;
          end else if (!sts.in_grid) begin
            cmd.res_idle = 1'b1;
            state_nxt    = ST_OUT;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          reply_nxt = 1'b0;
          state_nxt = reply_r ? ST_OUT : ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_WB;
        end
      end
      ST_WB: begin
        cmd.wb    = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_scan_to_wb: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && sts.scan_last) |=> (state_r == ST_WB))
    else $error("scan did not hand over to write-back");

  a_restart_reply: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR && sts.clr_last && reply_r) |=> (state_r == ST_OUT))
    else $error("restart finished clearing without a result");

endmodule

>>> src/gme_dp.sv
module gme_dp
  import gme_pkg::*;
#(
  parameter int GRID_ROWS  = 16,
  parameter int GRID_COLS  = 16,
  parameter int CELL_WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  gme_cfg_t         cfg,
  input  logic [3:0]       in_obst,
  input  gme_cmd_t         cmd,
  output gme_sts_t         sts,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_arrived,
  output logic [2:0]       out_move,
  output logic [POS_W-1:0] out_new_row,
  output logic [POS_W-1:0] out_new_col
);

  localparam int DEPTH = GRID_ROWS * GRID_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = ($clog2(GRID_ROWS) > POS_W) ? $clog2(GRID_ROWS) : POS_W;
  localparam int CW    = ($clog2(GRID_COLS) > POS_W) ? $clog2(GRID_COLS) : POS_W;

  logic [RW-1:0]         pos_row_r;
  logic [CW-1:0]         pos_col_r;
  logic [3:0]            sens_r;
  logic [2:0]            scan_k_r;
  logic                  rd_pend_r;
  logic [1:0]            rd_slot_r;
  logic [AW-1:0]         clr_cnt_r;
  logic signed [CELL_WIDTH-1:0] val_r [4];
  logic [3:0]            oob_r;
  logic                  res_arrived_r;
  logic [2:0]            res_move_r;
  logic                  out_valid_r;
  logic                  out_arrived_r;
  logic [2:0]            out_move_r;
  logic [POS_W-1:0]      out_row_r;
  logic [POS_W-1:0]      out_col_r;

  logic [3:0]            nbr_ok;
  logic [AW-1:0]         cur_addr;
  logic [AW-1:0]         nbr_addr [4];
  logic [1:0]            k2;
  logic                  scan_here;
  logic                  ram_we;
  logic [AW-1:0]         ram_addr;
  logic [CELL_WIDTH-1:0] ram_wdata;
  logic [CELL_WIDTH-1:0] ram_rdata;
  logic [CELL_WIDTH-1:0] here_dec;
  logic [CELL_WIDTH-1:0] wb_val;
  logic [3:0]            blocked;
  logic                  dead_end;
  logic [2:0]            choice;
  logic [RW-1:0]         next_row;
  logic [CW-1:0]         next_col;
  logic                  row_in, col_in;

  // neighbor and grid checks
  assign nbr_ok[0] = (pos_row_r != '0);
  assign nbr_ok[1] = (({1'b0, pos_row_r} + (RW+1)'(1)) < (RW+1)'(GRID_ROWS));
  assign nbr_ok[2] = (pos_col_r != '0);
  assign nbr_ok[3] = (({1'b0, pos_col_r} + (CW+1)'(1)) < (CW+1)'(GRID_COLS));
  assign row_in    = ({1'b0, pos_row_r} < (RW+1)'(GRID_ROWS));
  assign col_in    = ({1'b0, pos_col_r} < (CW+1)'(GRID_COLS));

  assign cur_addr    = AW'(pos_row_r) * AW'(GRID_COLS) + AW'(pos_col_r);
  assign nbr_addr[0] = cur_addr - AW'(GRID_COLS);
  assign nbr_addr[1] = cur_addr + AW'(GRID_COLS);
  assign nbr_addr[2] = cur_addr - AW'(1);
  assign nbr_addr[3] = cur_addr + AW'(1);

  assign k2        = scan_k_r[1:0];
  assign scan_here = (scan_k_r == SLOT_HERE);

  assign sts.arrived   = (pos_row_r == RW'(cfg.dest_row)) && (pos_col_r == CW'(cfg.dest_col));
  assign sts.in_grid   = row_in && col_in;
  assign sts.clr_last  = (clr_cnt_r == AW'(DEPTH - 1));
  assign sts.scan_last = scan_here;
  assign sts.out_busy  = out_valid_r && !out_ready;

  // decision on the current cell
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      blocked[k] = oob_r[k] | (!val_r[k][CELL_WIDTH-1] && (val_r[k] != '0));
    end
    here_dec = (ram_rdata == {1'b1, {(CELL_WIDTH-1){1'b0}}}) ? ram_rdata
                                                              : ram_rdata - CELL_WIDTH'(1);
    dead_end = (3'($countones(blocked)) == 3'(DEAD_END_SIDES));
    wb_val   = dead_end ? CELL_WIDTH'(CELL_DEAD_END) : here_dec;
    choice   = MOVE_NONE;
    for (int k = 0; k < 4; k++) begin
      if (!blocked[k] && ((choice == MOVE_NONE) || (val_r[k] > val_r[choice[1:0]]))) begin
        choice = 3'(k);
      end
    end
  end

  always_comb begin
    next_row = pos_row_r;
    next_col = pos_col_r;
    unique case (choice)
      MOVE_UP:    next_row = pos_row_r - RW'(1);
      MOVE_DOWN:  next_row = pos_row_r + RW'(1);
      MOVE_LEFT:  next_col = pos_col_r - CW'(1);
      MOVE_RIGHT: next_col = pos_col_r + CW'(1);
      default: begin
        next_row = pos_row_r;
        next_col = pos_col_r;
      end
    endcase
  end

  // map port
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = cur_addr;
    ram_wdata = '0;
    priority if (cmd.clr_step) begin
      ram_we   = 1'b1;
      ram_addr = clr_cnt_r;
    end else if (cmd.scan_step) begin
      if (!scan_here && nbr_ok[k2]) begin
        ram_addr  = nbr_addr[k2];
        ram_we    = sens_r[k2];
        ram_wdata = CELL_WIDTH'(CELL_OBSTACLE);
      end
    end else if (cmd.wb) begin
      ram_we    = 1'b1;
      ram_wdata = wb_val;
    end else begin
      ram_we = 1'b0;
    end
  end

  gme_ram #(
    .WIDTH (CELL_WIDTH),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_row_r   <= '0;
      pos_col_r   <= '0;
      scan_k_r    <= '0;
      rd_pend_r   <= 1'b0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.capture) begin
        scan_k_r <= '0;
      end else if (cmd.scan_step) begin
        scan_k_r <= scan_k_r + 3'd1;
      end
      if (cmd.load_start) begin
        pos_row_r <= RW'(cfg.start_row);
        pos_col_r <= CW'(cfg.start_col);
      end else if (cmd.wb) begin
        pos_row_r <= next_row;
        pos_col_r <= next_col;
      end
      if (cmd.clr_step) begin
        clr_cnt_r <= sts.clr_last ? '0 : clr_cnt_r + AW'(1);
      end
      rd_pend_r <= cmd.scan_step && !scan_here && nbr_ok[k2] && !sens_r[k2];
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sens_r <= in_obst;
    end
    rd_slot_r <= k2;
    if (rd_pend_r) begin
      val_r[rd_slot_r] <= ram_rdata;
    end
    if (cmd.scan_step && !scan_here) begin
      oob_r[k2] <= !nbr_ok[k2];
      if (nbr_ok[k2] && sens_r[k2]) begin
        val_r[k2] <= CELL_WIDTH'(CELL_OBSTACLE);
      end
    end
    if (cmd.res_arrived) begin
      res_arrived_r <= 1'b1;
      res_move_r    <= MOVE_NONE;
    end else if (cmd.res_idle) begin
      res_arrived_r <= 1'b0;
      res_move_r    <= MOVE_NONE;
    end else if (cmd.wb) begin
      res_arrived_r <= 1'b0;
      res_move_r    <= choice;
    end
    if (cmd.out_load) begin
      out_arrived_r <= res_arrived_r;
      out_move_r    <= res_move_r;
      out_row_r     <= pos_row_r[POS_W-1:0];
      out_col_r     <= pos_col_r[POS_W-1:0];
    end
  end

  assign out_valid   = out_valid_r;
  assign out_arrived = out_arrived_r;
  assign out_move    = out_move_r;
  assign out_new_row = out_row_r;
  assign out_new_col = out_col_r;

  a_move_stays_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wb && choice != MOVE_NONE) |=> (row_in && col_in))
    else $error("move left the grid");

  a_reads_done_at_wb: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wb |-> !rd_pend_r)
    else $error("neighbor read still in flight at decision");

  a_arrived_no_move: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_arrived_r) |-> (out_move_r == MOVE_NONE))
    else $error("arrived result carries a move");

endmodule

>>> src/grid_maze_explorer_top.sv
// sequence: a step goes through neighbor scan, current-cell read, write-back
// and output; arrival/off-grid steps skip to output; a restart clears the map
// throughput: one item at a time, set by the single map memory port
// (one neighbor access per cycle, then current cell read and write-back)
// reset: synchronous active-low; clears control and config, then sweeps the
// map to zero with in_item.ready low
module grid_maze_explorer_top
  import gme_pkg::*;
#(
  parameter int GRID_ROWS  = 16,
  parameter int GRID_COLS  = 16,
  parameter int CELL_WIDTH = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  gme_in_if.sink            in_item,
  gme_out_if.source         out_item,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  gme_cfg_t cfg_r;
  gme_cmd_t cmd;
  gme_sts_t sts;
  logic     cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_START_ROW: cfg_r.start_row <= pwdata[POS_W-1:0];
        REG_START_COL: cfg_r.start_col <= pwdata[POS_W-1:0];
        REG_DEST_ROW:  cfg_r.dest_row  <= pwdata[POS_W-1:0];
        REG_DEST_COL:  cfg_r.dest_col  <= pwdata[POS_W-1:0];
        default: cfg_r <= cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_START_ROW: prdata = CFG_DW'(cfg_r.start_row);
      REG_START_COL: prdata = CFG_DW'(cfg_r.start_col);
      REG_DEST_ROW:  prdata = CFG_DW'(cfg_r.dest_row);
      REG_DEST_COL:  prdata = CFG_DW'(cfg_r.dest_col);
      default:       prdata = '0;
    endcase
  end

  gme_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_item.valid),
    .in_operation (in_item.operation),
    .in_ready     (in_item.ready),
    .cmd          (cmd),
    .sts          (sts)
  );

  gme_dp #(
    .GRID_ROWS  (GRID_ROWS),
    .GRID_COLS  (GRID_COLS),
    .CELL_WIDTH (CELL_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_obst     ({in_item.obstacle_right, in_item.obstacle_left,
                   in_item.obstacle_down, in_item.obstacle_up}),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_item.valid),
    .out_ready   (out_item.ready),
    .out_arrived (out_item.arrived),
    .out_move    (out_item.move),
    .out_new_row (out_item.new_row),
    .out_new_col (out_item.new_col)
  );

endmodule

>>> verif/grid_maze_explorer_top_tb.sv
`timescale 1ns / 100ps

module grid_maze_explorer_top_tb;
  import gme_pkg::*;

  localparam int GRID_R         = 16;
  localparam int GRID_C         = 16;
  localparam int CELL_W         = 8;
  localparam int CELL_LOWEST    = -(2 ** (CELL_W - 1));
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LOOP_STEPS     = 560;
  localparam int WALK_PHASES    = 6;
  localparam int WALK_STEPS     = 25;
  localparam int LONG_HOLD      = 300;

  localparam logic OP_STEP    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [3:0] obstacle;  // indexed by move code: up, down, left, right
  } nav_cmd_t;

  typedef struct packed {
    logic             arrived;
    logic [2:0]       move;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } nav_res_t;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  gme_in_if  in_if ();
  gme_out_if out_if ();

  grid_maze_explorer_top #(
    .GRID_ROWS (GRID_R),
    .GRID_COLS (GRID_C),
    .CELL_WIDTH(CELL_W)
  ) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_item (in_if),
    .out_item(out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predicted block state
  logic signed [CELL_W-1:0] visit_map [GRID_R*GRID_C];
  int pos_row;
  int pos_col;
  logic [POS_W-1:0] cfg_start_row;
  logic [POS_W-1:0] cfg_start_col;
  logic [POS_W-1:0] cfg_dest_row;
  logic [POS_W-1:0] cfg_dest_col;

  nav_res_t nav_expected [$];
  int errors;
  int rx_hold;
  int burst_left;
  int idle_cycles;
  bit tx_free;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic bit on_grid(input int r, input int c);
    return r >= 0 && c >= 0 && r < GRID_R && c < GRID_C;
  endfunction

  function automatic void neighbor(input int r, input int c, input int k,
                                   output int nr, output int nc);
    nr = r;
    nc = c;
    case (3'(k))
      MOVE_UP:   nr = r - 1;
      MOVE_DOWN: nr = r + 1;
      MOVE_LEFT: nc = c - 1;
      default:   nc = c + 1;
    endcase
  endfunction

  task automatic predict_nav(input nav_cmd_t c);
    int nr;
    int nc;
    int here;
    int nblk;
    logic signed [CELL_W-1:0] val [4];
    logic [3:0] blk;
    logic [2:0] pick;
    nav_res_t res;
    res.arrived = 1'b0;
    pick = MOVE_NONE;
    if (c.operation == OP_RESTART) begin
      foreach (visit_map[i]) visit_map[i] = '0;
      pos_row = int'(cfg_start_row);
      pos_col = int'(cfg_start_col);
    end else if (pos_row == cfg_dest_row && pos_col == cfg_dest_col) begin
      res.arrived = 1'b1;
    end else begin
      nblk = 0;
      for (int k = 0; k < 4; k++) begin
        neighbor(pos_row, pos_col, k, nr, nc);
        if (!on_grid(nr, nc)) begin
          blk[k] = 1'b1;
          val[k] = '0;
        end else begin
          if (c.obstacle[k]) visit_map[nr*GRID_C+nc] = CELL_W'(CELL_OBSTACLE);
          val[k] = visit_map[nr*GRID_C+nc];
          blk[k] = val[k] >= 1;
        end
        if (blk[k]) nblk++;
        else if (pick == MOVE_NONE || val[k] > val[pick]) pick = 3'(k);
      end
      here = pos_row * GRID_C + pos_col;
      if (visit_map[here] > CELL_LOWEST) visit_map[here] = visit_map[here] - CELL_W'(1);
      if (nblk == DEAD_END_SIDES) visit_map[here] = CELL_W'(CELL_DEAD_END);
      if (pick != MOVE_NONE) neighbor(pos_row, pos_col, int'(pick), pos_row, pos_col);
    end
    res.move = pick;
    res.row = POS_W'(pos_row);
    res.col = POS_W'(pos_col);
    nav_expected.push_back(res);
  endtask

  task automatic send_nav(input nav_cmd_t c);
    int gap;
    gap = 0;
    if (!tx_free) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 12);
        burst_left = $urandom_range(1, 16);
      end
      burst_left--;
    end
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.operation <= c.operation;
    in_if.obstacle_up <= c.obstacle[MOVE_UP];
    in_if.obstacle_down <= c.obstacle[MOVE_DOWN];
    in_if.obstacle_left <= c.obstacle[MOVE_LEFT];
    in_if.obstacle_right <= c.obstacle[MOVE_RIGHT];
    do @(posedge clk); while (!in_if.ready);
    predict_nav(c);
  endtask

  task automatic send_step(input logic [3:0] obstacle);
    nav_cmd_t c;
    c.operation = OP_STEP;
    c.obstacle = obstacle;
    send_nav(c);
  endtask

  task automatic send_restart();
    nav_cmd_t c;
    c.operation = OP_RESTART;
    c.obstacle = 4'($urandom_range(0, 15));
    send_nav(c);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (nav_expected.size() != 0) @(posedge clk);
  endtask

  // leaves psel high for back-to-back writes
  task automatic write_reg(input logic [1:0] idx, input logic [POS_W-1:0] value);
    logic [CFG_DW-1:0] word;
    word = $urandom();
    if ($urandom_range(0, 1)) word = '0;
    word[POS_W-1:0] = value;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_START_ROW: cfg_start_row = word[POS_W-1:0];
      REG_START_COL: cfg_start_col = word[POS_W-1:0];
      REG_DEST_ROW:  cfg_dest_row = word[POS_W-1:0];
      default:       cfg_dest_col = word[POS_W-1:0];
    endcase
  endtask

  task automatic set_cfg(input int sr, input int sc, input int dr, input int dc);
    write_reg(REG_START_ROW, POS_W'(sr));
    write_reg(REG_START_COL, POS_W'(sc));
    write_reg(REG_DEST_ROW, POS_W'(dr));
    write_reg(REG_DEST_COL, POS_W'(dc));
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // sensing that keeps the robot circling a 2x2 block of open cells
  function automatic nav_cmd_t loop_sensing(input int base_r, input int base_c);
    nav_cmd_t c;
    int nr;
    int nc;
    c.operation = OP_STEP;
    for (int k = 0; k < 4; k++) begin
      neighbor(pos_row, pos_col, k, nr, nc);
      if (!on_grid(nr, nc))
        c.obstacle[k] = 1'($urandom_range(0, 1));
      else if (nr - base_r inside {0, 1} && nc - base_c inside {0, 1})
        c.obstacle[k] = 1'b0;
      else if (visit_map[nr*GRID_C+nc] >= 1)
        c.obstacle[k] = 1'($urandom_range(0, 1));
      else
        c.obstacle[k] = 1'b1;
    end
    return c;
  endfunction

  task automatic test_reset_defaults();
    send_step(4'b0000);
    send_step(4'b1111);
    wait_drained();
  endtask

  task automatic test_grid_edges();
    set_cfg(0, 0, 15, 15);
    send_restart();
    send_step(4'b0101);
    send_step(4'b0000);
    wait_drained();
    set_cfg(15, 15, 0, 0);
    send_restart();
    send_step(4'b1010);
    send_step(4'b0000);
    wait_drained();
  endtask

  task automatic test_obstacle_patterns();
    set_cfg(7, 9, 0, 0);
    send_restart();
    for (int p = 0; p < 16; p++) send_step(4'(p));
    wait_drained();
  endtask

  task automatic test_dead_end_stuck();
    set_cfg(0, 0, 15, 15);
    send_restart();
    send_step({1'b0, 1'($urandom_range(0, 1)), 1'b1, 1'($urandom_range(0, 1))});
    send_step(4'b1010);
    send_step(4'($urandom_range(0, 15)));
    send_step(4'($urandom_range(0, 15)));
    wait_drained();
  endtask

  task automatic test_arrival();
    set_cfg(5, 5, 5, 5);
    send_restart();
    send_step(4'($urandom_range(0, 15)));
    send_step(4'($urandom_range(0, 15)));
    wait_drained();
    set_cfg(5, 5, 5, 6);
    send_step(4'b0111);
    send_step(4'b0000);
    send_restart();
    send_step(4'b0000);
    wait_drained();
  endtask

  task automatic test_visit_saturation();
    int base_r;
    int base_c;
    base_r = $urandom_range(0, GRID_R - 2);
    base_c = $urandom_range(0, GRID_C - 2);
    set_cfg(base_r, base_c, (base_r + 8) % GRID_R, base_c);
    send_restart();
    for (int i = 0; i < LOOP_STEPS; i++) send_nav(loop_sensing(base_r, base_c));
    wait_drained();
  endtask

  task automatic test_backpressure();
    nav_cmd_t c;
    tx_free = 1'b1;
    rx_hold = LONG_HOLD;
    send_restart();
    for (int i = 0; i < 12; i++) begin
      c.operation = OP_STEP;
      c.obstacle = 4'($urandom_range(0, 15));
      send_nav(c);
    end
    wait_drained();
    tx_free = 1'b0;
  endtask

  task automatic test_random_walks();
    int sr;
    int sc;
    int dr;
    int dc;
    nav_cmd_t c;
    for (int ph = 0; ph < WALK_PHASES; ph++) begin
      sr = $urandom_range(0, 15);
      sc = $urandom_range(0, 15);
      if ($urandom_range(0, 1)) begin
        dr = (sr + $urandom_range(0, 6) - 3) & 15;
        dc = (sc + $urandom_range(0, 6) - 3) & 15;
      end else begin
        dr = $urandom_range(0, 15);
        dc = $urandom_range(0, 15);
      end
      case (ph)
        0: set_cfg(0, 0, 15, 15);
        1: set_cfg(15, 15, 0, 0);
        2: set_cfg(0, 15, 15, 0);
        default: set_cfg(sr, sc, dr, dc);
      endcase
      tx_free = (ph % 3 == 0);
      send_restart();
      for (int i = 0; i < WALK_STEPS; i++) begin
        c.operation = ($urandom_range(0, 29) == 0) ? OP_RESTART : OP_STEP;
        for (int k = 0; k < 4; k++) c.obstacle[k] = ($urandom_range(0, 5) == 0);
        send_nav(c);
      end
      wait_drained();
    end
    tx_free = 1'b0;
  endtask

  // receiver stall pattern: free-running stretches and choppy stretches
  initial begin : rx_pattern
    int stall_left;
    int mode_left;
    bit choppy;
    out_if.ready = 1'b0;
    stall_left = 0;
    mode_left = 0;
    choppy = 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        choppy = $urandom_range(0, 2) != 0;
        mode_left = $urandom_range(50, 400);
      end
      mode_left--;
      if (rx_hold > 0) begin
        rx_hold--;
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (choppy && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 19);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    nav_res_t got;
    nav_res_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.arrived = out_if.arrived;
      got.move = out_if.move;
      got.row = out_if.new_row;
      got.col = out_if.new_col;
      if (nav_expected.size() == 0) begin
        $display("%0t: transfer with no result expected, got %p", $time, got);
        errors++;
      end else begin
        want = nav_expected.pop_front();
        if (got.arrived !== want.arrived) begin
          $display("%0t: arrived expected %0d got %0d", $time, want.arrived, got.arrived);
          errors++;
        end
        if (got.move !== want.move) begin
          $display("%0t: move expected %0d got %0d", $time, want.move, got.move);
          errors++;
        end
        if (got.row !== want.row) begin
          $display("%0t: new_row expected %0d got %0d", $time, want.row, got.row);
          errors++;
        end
        if (got.col !== want.col) begin
          $display("%0t: new_col expected %0d got %0d", $time, want.col, got.col);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.operation = OP_STEP;
    in_if.obstacle_up = 1'b0;
    in_if.obstacle_down = 1'b0;
    in_if.obstacle_left = 1'b0;
    in_if.obstacle_right = 1'b0;
    errors = 0;
    rx_hold = 0;
    burst_left = 0;
    idle_cycles = 0;
    tx_free = 1'b0;
    pos_row = 0;
    pos_col = 0;
    cfg_start_row = '0;
    cfg_start_col = '0;
    cfg_dest_row = '0;
    cfg_dest_col = '0;
    foreach (visit_map[i]) visit_map[i] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_grid_edges();
    test_obstacle_patterns();
    test_dead_end_stuck();
    test_arrival();
    test_backpressure();
    test_visit_saturation();
    test_random_walks();

    wait_drained();
    repeat (20) @(posedge clk);
    if (nav_expected.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, nav_expected.size());
      errors++;
    end
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> sim.f
src/gme_pkg.sv
src/gme_in_if.sv
src/gme_out_if.sv
src/gme_ram.sv
src/gme_ctrl.sv
src/gme_dp.sv
src/grid_maze_explorer_top.sv
verif/grid_maze_explorer_top_tb.sv
